// ----- hw/rtl/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the rotation-to-quaternion block
// Beat layouts, pivot codes and width helpers used by all files.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int WORD_W        = 16;
  localparam int FRAC_BITS_DEF = 14;
  // Off-diagonal sums and differences need one bit more than a word.
  localparam int NUM_W         = WORD_W + 1;
  // Quotients stay below 2^16 + 2, so this many bits hold them.
  localparam int QUO_W         = WORD_W + 1;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [1:0] PIV_X = 2'd0;
  localparam logic [1:0] PIV_Y = 2'd1;
  localparam logic [1:0] PIV_Z = 2'd2;
  localparam logic [1:0] PIV_W = 2'd3;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 16'sh7fff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [WORD_W-1:0] right_x;
    logic signed [WORD_W-1:0] right_y;
    logic signed [WORD_W-1:0] right_z;
    logic signed [WORD_W-1:0] up_x;
    logic signed [WORD_W-1:0] up_y;
    logic signed [WORD_W-1:0] up_z;
    logic signed [WORD_W-1:0] fwd_x;
    logic signed [WORD_W-1:0] fwd_y;
    logic signed [WORD_W-1:0] fwd_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] q_x;
    logic signed [WORD_W-1:0] q_y;
    logic signed [WORD_W-1:0] q_z;
    logic signed [WORD_W-1:0] q_w;
    logic [1:0]               pivot_index;
  } out_beat_t;

  // Signed width of a candidate 1 +/- three diagonal terms.
  function automatic int cand_sw(input int f);
    return ((f > NUM_W) ? f : NUM_W) + 2;
  endfunction

  // Width of one queued job: pivot, clamped best candidate, three numerators.
  function automatic int job_w(input int f);
    return 2 + (cand_sw(f) - 1) + 3 * NUM_W;
  endfunction

endpackage

// ----- hw/rtl/rmq_in_if.sv -----
// ----------------------------------------------------------------------------
// rmq_in_if: input channel carrying one rotation basis per beat
// Valid/ready handshake with the nine basis components as payload.
// ----------------------------------------------------------------------------
interface rmq_in_if import rmq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rmq_out_if.sv -----
// ----------------------------------------------------------------------------
// rmq_out_if: result channel carrying one quaternion per beat
// Valid/ready handshake with the quaternion and pivot index as payload.
// ----------------------------------------------------------------------------
interface rmq_out_if import rmq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rmq_front.sv -----
// ----------------------------------------------------------------------------
// rmq_front: candidate forming and pivot selection
// Builds the four clamped candidates, picks the pivot and the numerators.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  rmq_in_if.sink                       in_ch,
  output logic                         job_valid,
  input  logic                         job_ready,
  output logic [job_w(FRAC_BITS)-1:0]  job_data
);

  localparam int CSW = cand_sw(FRAC_BITS);
  localparam int CUW = CSW - 1;
  localparam logic signed [CSW-1:0] ONE = CSW'(1) << FRAC_BITS;

  logic signed [CSW-1:0] rx, uy, fz;
  logic signed [CSW-1:0] cand0, cand1, cand2, cand3;
  logic [CUW-1:0]        cl0, cl1, cl2, cl3, best;
  logic [1:0]            piv;
  logic signed [NUM_W-1:0] n_a, n_b, n_c, n_d, n_e, n_f;
  logic signed [NUM_W-1:0] n0, n1, n2;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid;

  always_comb begin
    rx = CSW'(in_ch.data.right_x);
    uy = CSW'(in_ch.data.up_y);
    fz = CSW'(in_ch.data.fwd_z);
    cand0 = ONE + rx - uy - fz;
    cand1 = ONE + uy - rx - fz;
    cand2 = ONE + fz - rx - uy;
    cand3 = ONE + rx + uy + fz;
    cl0 = cand0[CSW-1] ? '0 : cand0[CUW-1:0];
    cl1 = cand1[CSW-1] ? '0 : cand1[CUW-1:0];
    cl2 = cand2[CSW-1] ? '0 : cand2[CUW-1:0];
    cl3 = cand3[CSW-1] ? '0 : cand3[CUW-1:0];
    // Strictly greater, so the earlier candidate keeps a tie.
    best = cl0;
    piv  = PIV_X;
    if (cl1 > best) begin
      best = cl1;
      piv  = PIV_Y;
    end
    if (cl2 > best) begin
      best = cl2;
      piv  = PIV_Z;
    end
    if (cl3 > best) begin
      best = cl3;
      piv  = PIV_W;
    end
  end

  always_comb begin
    n_a = NUM_W'(in_ch.data.right_y) + NUM_W'(in_ch.data.up_x);
    n_b = NUM_W'(in_ch.data.fwd_x) + NUM_W'(in_ch.data.right_z);
    n_c = NUM_W'(in_ch.data.up_z) - NUM_W'(in_ch.data.fwd_y);
    n_d = NUM_W'(in_ch.data.up_z) + NUM_W'(in_ch.data.fwd_y);
    n_e = NUM_W'(in_ch.data.fwd_x) - NUM_W'(in_ch.data.right_z);
    n_f = NUM_W'(in_ch.data.right_y) - NUM_W'(in_ch.data.up_x);
    // The three non-pivot components, in ascending component order.
    case (piv)
      PIV_X: begin
        n0 = n_a; n1 = n_b; n2 = n_c;
      end
      PIV_Y: begin
        n0 = n_a; n1 = n_d; n2 = n_e;
      end
      PIV_Z: begin
        n0 = n_b; n1 = n_d; n2 = n_f;
      end
      default: begin
        n0 = n_c; n1 = n_e; n2 = n_f;
      end
    endcase
  end

  assign job_data = {piv, best, n0, n1, n2};

endmodule

// ----- hw/rtl/rmq_fifo.sv -----
// ----------------------------------------------------------------------------
// rmq_fifo: short job queue between the front and the back
// Register-based FIFO with a combinational head read.
// ----------------------------------------------------------------------------
module rmq_fifo import rmq_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [0:DEPTH-1];
  logic [AW-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  assign wr_ready = (cnt_r != CNTW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/rmq_back.sv -----
// ----------------------------------------------------------------------------
// rmq_back: square root, scaled division and output register
// Bit-per-stage square root, then three bit-per-stage dividers in parallel.
// ----------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  logic [job_w(FRAC_BITS)-1:0] job_data,
  rmq_out_if.source                   out_ch
);

  localparam int JW   = job_w(FRAC_BITS);
  localparam int CUW  = cand_sw(FRAC_BITS) - 1;
  localparam int RW   = CUW + FRAC_BITS;
  localparam int SW   = (RW + 1) / 2;
  localparam int XW   = 2 * SW;
  localparam int RRW  = SW + 3;
  localparam int CW   = SW - 1;
  localparam int DW   = CW + 3;
  localparam int MW   = NUM_W + FRAC_BITS + 2;
  localparam int EW   = (MW > DW + QUO_W) ? MW : DW + QUO_W;
  localparam int CEXT = CW + WORD_W;

  logic en;

  // Job fields.
  logic [1:0]              j_piv;
  logic [CUW-1:0]          j_best;
  logic signed [NUM_W-1:0] j_num [0:2];

  assign j_piv    = job_data[JW-1 -: 2];
  assign j_best   = job_data[JW-3 -: CUW];
  assign j_num[0] = job_data[3*NUM_W-1 -: NUM_W];
  assign j_num[1] = job_data[2*NUM_W-1 -: NUM_W];
  assign j_num[2] = job_data[NUM_W-1 -: NUM_W];

  // Square-root stages.
  logic                    sq_v_r    [0:SW-1];
  logic [XW-1:0]           sq_x_r    [0:SW-1];
  logic [RRW-1:0]          sq_rem_r  [0:SW-1];
  logic [SW-1:0]           sq_root_r [0:SW-1];
  logic [1:0]              sq_piv_r  [0:SW-1];
  logic signed [NUM_W-1:0] sq_num_r  [0:SW-1][0:2];

  // Divider setup stage.
  logic                    pp_v_r;
  logic [1:0]              pp_piv_r;
  logic [CW-1:0]           pp_c_r;
  logic [DW-1:0]           pp_d_r;
  logic                    pp_neg_r [0:2];
  logic [EW-1:0]           pp_rem_r [0:2];

  // Divider stages.
  logic                    dv_v_r   [0:QUO_W-1];
  logic [1:0]              dv_piv_r [0:QUO_W-1];
  logic [CW-1:0]           dv_c_r   [0:QUO_W-1];
  logic [DW-1:0]           dv_d_r   [0:QUO_W-1];
  logic                    dv_neg_r [0:QUO_W-1][0:2];
  logic [EW-1:0]           dv_rem_r [0:QUO_W-1][0:2];
  logic [QUO_W-1:0]        dv_quo_r [0:QUO_W-1][0:2];

  logic      out_v_r;
  out_beat_t out_beat_r, out_beat_nxt;

  assign en        = !out_v_r || out_ch.ready;
  assign job_ready = en;

  genvar i, k;
  generate
    for (i = 0; i < SW; i++) begin : g_sq
      logic                    v_in;
      logic [XW-1:0]           x_in;
      logic [RRW-1:0]          rem_in, rem_sh, trial, rem_nxt;
      logic [SW-1:0]           root_in, root_nxt;
      logic [1:0]              piv_in;
      logic signed [NUM_W-1:0] num_in [0:2];

      if (i == 0) begin : g_first
        assign v_in    = job_valid;
        assign x_in    = XW'({j_best, {FRAC_BITS{1'b0}}});
        assign rem_in  = '0;
        assign root_in = '0;
        assign piv_in  = j_piv;
        for (k = 0; k < 3; k++) begin : g_n
          assign num_in[k] = j_num[k];
        end
      end else begin : g_next
        assign v_in    = sq_v_r[i-1];
        assign x_in    = sq_x_r[i-1];
        assign rem_in  = sq_rem_r[i-1];
        assign root_in = sq_root_r[i-1];
        assign piv_in  = sq_piv_r[i-1];
        for (k = 0; k < 3; k++) begin : g_n
          assign num_in[k] = sq_num_r[i-1][k];
        end
      end

      always_comb begin
        rem_sh = {rem_in[RRW-3:0], x_in[XW-1 -: 2]};
        trial  = RRW'({root_in, 2'b01});
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_in[SW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_in[SW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[i] <= 1'b0;
        end else if (en) begin
          sq_v_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sq_x_r[i]    <= x_in << 2;
          sq_rem_r[i]  <= rem_nxt;
          sq_root_r[i] <= root_nxt;
          sq_piv_r[i]  <= piv_in;
          for (int m = 0; m < 3; m++) begin
            sq_num_r[i][m] <= num_in[m];
          end
        end
      end
    end
  endgenerate

  // Divider setup: pivot value C is half the root; each lane divides
  // |n| * 2^(F+1) + 4C by 8C, which rounds |n| * 2^F / 4C half away from zero.
  logic [CW-1:0]    c_val;
  logic [QUO_W-1:0] mag   [0:2];
  logic             neg   [0:2];
  logic [EW-1:0]    numer [0:2];

  always_comb begin
    c_val = sq_root_r[SW-1][SW-1:1];
    for (int m = 0; m < 3; m++) begin
      neg[m]   = sq_num_r[SW-1][m][NUM_W-1];
      mag[m]   = neg[m] ? QUO_W'(-sq_num_r[SW-1][m]) : QUO_W'(sq_num_r[SW-1][m]);
      numer[m] = EW'({mag[m], {(FRAC_BITS + 1){1'b0}}}) + EW'({c_val, 2'b00});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_v_r <= 1'b0;
    end else if (en) begin
      pp_v_r <= sq_v_r[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_piv_r <= sq_piv_r[SW-1];
      pp_c_r   <= c_val;
      pp_d_r   <= {c_val, 3'b000};
      for (int m = 0; m < 3; m++) begin
        pp_neg_r[m] <= neg[m];
        pp_rem_r[m] <= numer[m];
      end
    end
  end

  generate
    for (i = 0; i < QUO_W; i++) begin : g_dv
      localparam int SH = QUO_W - 1 - i;
      logic             v_in;
      logic [1:0]       piv_in;
      logic [CW-1:0]    c_in;
      logic [DW-1:0]    d_in;
      logic [EW-1:0]    dsh;
      logic             neg_in  [0:2];
      logic [EW-1:0]    rem_in  [0:2];
      logic [QUO_W-1:0] quo_in  [0:2];
      logic [EW-1:0]    rem_nxt [0:2];
      logic [QUO_W-1:0] quo_nxt [0:2];

      if (i == 0) begin : g_first
        assign v_in   = pp_v_r;
        assign piv_in = pp_piv_r;
        assign c_in   = pp_c_r;
        assign d_in   = pp_d_r;
        for (k = 0; k < 3; k++) begin : g_l
          assign neg_in[k] = pp_neg_r[k];
          assign rem_in[k] = pp_rem_r[k];
          assign quo_in[k] = '0;
        end
      end else begin : g_next
        assign v_in   = dv_v_r[i-1];
        assign piv_in = dv_piv_r[i-1];
        assign c_in   = dv_c_r[i-1];
        assign d_in   = dv_d_r[i-1];
        for (k = 0; k < 3; k++) begin : g_l
          assign neg_in[k] = dv_neg_r[i-1][k];
          assign rem_in[k] = dv_rem_r[i-1][k];
          assign quo_in[k] = dv_quo_r[i-1][k];
        end
      end

      assign dsh = EW'(d_in) << SH;

      always_comb begin
        for (int m = 0; m < 3; m++) begin
          if (rem_in[m] >= dsh) begin
            rem_nxt[m] = rem_in[m] - dsh;
            quo_nxt[m] = {quo_in[m][QUO_W-2:0], 1'b1};
          end else begin
            rem_nxt[m] = rem_in[m];
            quo_nxt[m] = {quo_in[m][QUO_W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_v_r[i] <= 1'b0;
        end else if (en) begin
          dv_v_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dv_piv_r[i] <= piv_in;
          dv_c_r[i]   <= c_in;
          dv_d_r[i]   <= d_in;
          for (int m = 0; m < 3; m++) begin
            dv_neg_r[i][m] <= neg_in[m];
            dv_rem_r[i][m] <= rem_nxt[m];
            dv_quo_r[i][m] <= quo_nxt[m];
          end
        end
      end
    end
  endgenerate

  // Sign, saturation and placement of the pivot component.
  logic signed [QUO_W:0]    val   [0:2];
  logic signed [WORD_W-1:0] lane  [0:2];
  logic signed [WORD_W-1:0] c_sat;

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      val[m] = $signed({1'b0, dv_quo_r[QUO_W-1][m]});
      if (dv_neg_r[QUO_W-1][m]) begin
        val[m] = -val[m];
      end
      if (val[m] > (QUO_W + 1)'(WORD_MAX)) begin
        lane[m] = WORD_MAX;
      end else if (val[m] < (QUO_W + 1)'(WORD_MIN)) begin
        lane[m] = WORD_MIN;
      end else begin
        lane[m] = val[m][WORD_W-1:0];
      end
    end
    if (CEXT'(dv_c_r[QUO_W-1]) > CEXT'(WORD_MAX)) begin
      c_sat = WORD_MAX;
    end else begin
      c_sat = WORD_W'(dv_c_r[QUO_W-1]);
    end
    out_beat_nxt.pivot_index = dv_piv_r[QUO_W-1];
    case (dv_piv_r[QUO_W-1])
      PIV_X: begin
        out_beat_nxt.q_x = c_sat;   out_beat_nxt.q_y = lane[0];
        out_beat_nxt.q_z = lane[1]; out_beat_nxt.q_w = lane[2];
      end
      PIV_Y: begin
        out_beat_nxt.q_x = lane[0]; out_beat_nxt.q_y = c_sat;
        out_beat_nxt.q_z = lane[1]; out_beat_nxt.q_w = lane[2];
      end
      PIV_Z: begin
        out_beat_nxt.q_x = lane[0]; out_beat_nxt.q_y = lane[1];
        out_beat_nxt.q_z = c_sat;   out_beat_nxt.q_w = lane[2];
      end
      default: begin
        out_beat_nxt.q_x = lane[0]; out_beat_nxt.q_y = lane[1];
        out_beat_nxt.q_z = lane[2]; out_beat_nxt.q_w = c_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_beat_r;

endmodule

// ----- hw/rtl/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: rotation basis to unit quaternion
// Shepperd's method in fixed point with a pipelined root and divider.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                     Beat
//   in_ch    in   right/up/fwd x,y,z, signed, FRAC_BITS frac  one basis
//   out_ch   out  q_x q_y q_z q_w (saturated), pivot_index    one quaternion
//
// The block takes one beat per clock while the job queue has room and
// returns one result per beat. SW is the number of square-root bits (one
// stage each) and QUO_W = 17 is the number of quotient bits (one divider
// stage each); inputs are Q2.14 by default. Reset is synchronous and active
// low; it clears only valid and pointer state. When the result side stalls,
// the back pipeline holds as a whole and the job queue keeps taking beats
// until it fills.
//
// The front forms the four candidates 1 +/- the diagonal terms, clamps them
// at zero, and picks the largest with the first one winning ties. It also
// selects the three off-diagonal sums or differences that belong to that
// pivot. The job sits in a two-entry queue, so the front and back stall on
// their own. The back takes the integer square root of the candidate scaled
// by 2^FRAC_BITS one root bit per stage, halves it to get the pivot
// component C, and then runs three restoring dividers side by side that
// produce each other component rounded to nearest, halves away from zero.
// The largest candidate is at least one, so C never reaches zero.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);

  localparam int JW = job_w(FRAC_BITS);

  logic          fr_valid, fr_ready;
  logic [JW-1:0] fr_data;
  logic          q_valid, q_ready;
  logic [JW-1:0] q_data;

  rmq_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_ch     (in_ch),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job_data  (fr_data)
  );

  rmq_fifo #(
    .W     (JW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  rmq_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job_data  (q_data),
    .out_ch    (out_ch)
  );

  // The pivot component is a square root, so it is never negative.
  a_pivot_nonneg : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      !((out_ch.data.pivot_index == PIV_X && out_ch.data.q_x[WORD_W-1]) ||
        (out_ch.data.pivot_index == PIV_Y && out_ch.data.q_y[WORD_W-1]) ||
        (out_ch.data.pivot_index == PIV_Z && out_ch.data.q_z[WORD_W-1]) ||
        (out_ch.data.pivot_index == PIV_W && out_ch.data.q_w[WORD_W-1])))
    else $error("pivot component of a result is negative");

  // An accepted beat is in the queue on the next cycle.
  a_queue_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> q_valid)
    else $error("accepted beat did not reach the job queue");

endmodule

// ----- tb/rotation_matrix_to_quaternion_test.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test: self-checking bench for the block
// Streams rotation bases through the block under random idling on both
// sides and compares every quaternion with a cycle-free software predictor.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam int FB      = FRAC_BITS_DEF;
  localparam int LATENCY = 36;
  localparam int N_RAND  = 950;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  in_beat_t  pending_bases[$];
  out_beat_t expected_quats[$];
  int        n_errors = 0;
  bit        stim_done = 1'b0;
  // Once set, neither side starts a new idle burst.
  bit        calm = 1'b0;
  // Forces a long receiver hold-off while the sender keeps offering beats.
  bit        hold_rx = 1'b0;

  // Integer square root, one result bit per step, as the block computes it.
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // n * 2^FB / den, rounded to nearest with halves away from zero.
  function automatic longint round_quot(input longint n, input longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (n < 0) ? longint'(-n) : n;
    q = ((mag << (FB + 1)) + den) / (den << 1);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [WORD_W-1:0] clip16(input longint v);
    if (v > 32767) return WORD_MAX;
    if (v < -32768) return WORD_MIN;
    return v[WORD_W-1:0];
  endfunction

  function automatic out_beat_t quat_of_basis(input in_beat_t b);
    longint          one, rx, ry, rz, ux, uy, uz, fx, fy, fz, best;
    longint          cand[4];
    longint          q[4];
    longint unsigned c, den;
    logic [1:0]      piv;
    out_beat_t       r;
    rx = b.right_x; ry = b.right_y; rz = b.right_z;
    ux = b.up_x;    uy = b.up_y;    uz = b.up_z;
    fx = b.fwd_x;   fy = b.fwd_y;   fz = b.fwd_z;
    one = longint'(1) << FB;
    cand[0] = one + rx - uy - fz;
    cand[1] = one + uy - rx - fz;
    cand[2] = one + fz - rx - uy;
    cand[3] = one + rx + uy + fz;
    for (int i = 0; i < 4; i++) if (cand[i] < 0) cand[i] = 0;
    // Strict comparison keeps the first candidate on ties.
    best = cand[0];
    piv = PIV_X;
    for (int i = 1; i < 4; i++) begin
      if (cand[i] > best) begin
        best = cand[i];
        piv = 2'(i);
      end
    end
    c = int_sqrt(longint'(best) << FB) >> 1;
    if (c == 0) c = 1;
    den = c << 2;
    case (piv)
      PIV_X: begin
        q[1] = round_quot(ry + ux, den);
        q[2] = round_quot(fx + rz, den);
        q[3] = round_quot(uz - fy, den);
      end
      PIV_Y: begin
        q[0] = round_quot(ry + ux, den);
        q[2] = round_quot(uz + fy, den);
        q[3] = round_quot(fx - rz, den);
      end
      PIV_Z: begin
        q[0] = round_quot(fx + rz, den);
        q[1] = round_quot(uz + fy, den);
        q[3] = round_quot(ry - ux, den);
      end
      default: begin
        q[0] = round_quot(uz - fy, den);
        q[1] = round_quot(fx - rz, den);
        q[2] = round_quot(ry - ux, den);
      end
    endcase
    // The pivot saturates on its own, but the full C stayed the divisor.
    q[piv] = longint'(c);
    r.q_x = clip16(q[0]);
    r.q_y = clip16(q[1]);
    r.q_z = clip16(q[2]);
    r.q_w = clip16(q[3]);
    r.pivot_index = piv;
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return WORD_W'($urandom_range(0, 32767));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  function automatic in_beat_t rand_basis();
    in_beat_t b;
    b.right_x = rand_word(); b.right_y = rand_word(); b.right_z = rand_word();
    b.up_x    = rand_word(); b.up_y    = rand_word(); b.up_z    = rand_word();
    b.fwd_x   = rand_word(); b.fwd_y   = rand_word(); b.fwd_z   = rand_word();
    return b;
  endfunction

  // A signed permutation basis that makes the given diagonal dominant, with
  // small random perturbations so the off-diagonal terms are not all zero.
  function automatic in_beat_t near_rotation(input logic [1:0] piv);
    in_beat_t b;
    logic signed [WORD_W-1:0] o, e;
    o = WORD_W'(16384);
    b = '0;
    case (piv)
      PIV_X: begin b.right_x = o;  b.up_y = -o; b.fwd_z = -o; end
      PIV_Y: begin b.right_x = -o; b.up_y = o;  b.fwd_z = -o; end
      PIV_Z: begin b.right_x = -o; b.up_y = -o; b.fwd_z = o;  end
      default: begin b.right_x = o; b.up_y = o; b.fwd_z = o;  end
    endcase
    e = WORD_W'($urandom_range(0, 4095)) - WORD_W'(2048);
    b.right_y = e;  b.up_x  = -e + WORD_W'($urandom_range(0, 3));
    e = WORD_W'($urandom_range(0, 4095)) - WORD_W'(2048);
    b.right_z = e;  b.fwd_x = e + WORD_W'($urandom_range(0, 3));
    e = WORD_W'($urandom_range(0, 4095)) - WORD_W'(2048);
    b.up_z = e;     b.fwd_y = -e;
    b.right_x += WORD_W'($urandom_range(0, 511)) - WORD_W'(256);
    return b;
  endfunction

  // Stimulus: directed corners first, then mostly rotation-like bases.
  initial begin
    in_beat_t b;
    b = '0;                                         pending_bases.push_back(b);
    b = '1;                                         pending_bases.push_back(b);
    b = {9{WORD_MAX}};                              pending_bases.push_back(b);
    b = {9{WORD_MIN}};                              pending_bases.push_back(b);
    // Identity: the w candidate dominates.
    b = '0; b.right_x = 16384; b.up_y = 16384; b.fwd_z = 16384;
    pending_bases.push_back(b);
    for (int p = 0; p < 4; p++) pending_bases.push_back(near_rotation(2'(p)));
    // Equal candidates: the first one must win the tie.
    b = '0; b.right_x = -16384; b.up_y = -16384; b.fwd_z = -16384;
    pending_bases.push_back(b);
    b = '0; pending_bases.push_back(b);
    // Huge pivot: C takes its largest value, still within the word range.
    b = '0; b.right_x = WORD_MAX; b.up_y = WORD_MIN; b.fwd_z = WORD_MIN;
    b.right_y = WORD_MAX; b.up_x = WORD_MAX;
    pending_bases.push_back(b);
    b = '0; b.right_x = WORD_MAX; b.up_y = WORD_MAX; b.fwd_z = WORD_MAX;
    b.up_z = WORD_MAX; b.fwd_y = WORD_MIN; b.fwd_x = WORD_MIN; b.right_z = WORD_MAX;
    pending_bases.push_back(b);
    // Largest numerators with a three-way candidate tie: results stay in range.
    b = '0; b.up_y = WORD_MIN; b.fwd_z = WORD_MIN; b.right_x = WORD_MIN;
    b.right_y = WORD_MAX; b.up_x = WORD_MAX; b.fwd_x = WORD_MIN; b.right_z = WORD_MIN;
    b.up_z = WORD_MAX; b.fwd_y = WORD_MIN;
    pending_bases.push_back(b);
    // Rounding: numerators of one and three units against a unit pivot C.
    b = '0; b.right_x = 16384; b.up_y = 16384; b.fwd_z = 16384; b.right_y = 1;
    pending_bases.push_back(b);
    b.right_y = -1; pending_bases.push_back(b);
    b.right_y = 2;  b.up_x = -1; pending_bases.push_back(b);
    for (int i = 0; i < N_RAND; i++) begin
      if ($urandom_range(0, 3) == 0) pending_bases.push_back(rand_basis());
      else pending_bases.push_back(near_rotation(2'($urandom)));
    end
  end

  // Sender: walks the pending queue, idling in random bursts.
  int tx_idle = 0;
  // Set when the offered beat was taken at the last rising edge.
  bit tx_fire = 1'b0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    tx_fire <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (tx_fire) begin
        expected_quats.push_back(quat_of_basis(in_ch.data));
        void'(pending_bases.pop_front());
      end
      if (tx_idle > 0) begin
        tx_idle <= tx_idle - 1;
        in_ch.valid <= 1'b0;
      end else if (!calm && !(in_ch.valid && !tx_fire) && $urandom_range(0, 9) == 0) begin
        // An offered beat is never withdrawn, so bursts start between beats.
        tx_idle <= $urandom_range(1, 12) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_bases.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_bases[0];
      end else begin
        in_ch.valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Receiver: random stall bursts, plus the forced long hold-off.
  int rx_idle = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
      end else if (rx_idle > 0) begin
        rx_idle <= rx_idle - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rx_idle <= $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expected quaternion.
  always @(posedge clk) begin
    out_beat_t exp_q;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: result beat with nothing expected: %p", $time, out_ch.data);
        n_errors++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (exp_q.q_x !== out_ch.data.q_x)
          $display("%0t: q_x expected %0d actual %0d", $time, exp_q.q_x, out_ch.data.q_x);
        if (exp_q.q_y !== out_ch.data.q_y)
          $display("%0t: q_y expected %0d actual %0d", $time, exp_q.q_y, out_ch.data.q_y);
        if (exp_q.q_z !== out_ch.data.q_z)
          $display("%0t: q_z expected %0d actual %0d", $time, exp_q.q_z, out_ch.data.q_z);
        if (exp_q.q_w !== out_ch.data.q_w)
          $display("%0t: q_w expected %0d actual %0d", $time, exp_q.q_w, out_ch.data.q_w);
        if (exp_q.pivot_index !== out_ch.data.pivot_index)
          $display("%0t: pivot expected %0d actual %0d", $time,
                   exp_q.pivot_index, out_ch.data.pivot_index);
        if (exp_q !== out_ch.data) n_errors++;
      end
    end
  end

  // Sequencing: reset, a long result stall early on, a calm tail, then the end.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    repeat (60) @(posedge clk);
    // The pipeline and job queue fill, so the block must stall its input.
    @(negedge clk) hold_rx <= 1'b1;
    for (int i = 0; i < 150; i++) @(posedge clk);
    @(negedge clk) hold_rx <= 1'b0;
    wait (pending_bases.size() < 150);
    calm = 1'b1;
    wait (stim_done && expected_quats.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && expected_quats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: roughly 1000 beats with worst-case gaps is well under this.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
